// ===== hdl/lfu_pkg.sv =====
package lfu_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 64;
    localparam int COUNT_BITS = 16;
    localparam int IDX_BITS   = $clog2(ENTRIES);

    typedef enum logic [1:0] {
        REQ_GET = 2'd0,
        REQ_SET = 2'd1,
        REQ_DEL = 2'd2,
        REQ_CLR = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } t_state;

    typedef struct packed {
        t_req_type               req_type;
        logic [KEY_BITS-1:0]     key;
        logic [VALUE_BITS-1:0]   value;
    } t_req;

    typedef struct packed {
        logic                    hit;
        logic [VALUE_BITS-1:0]   value_out;
    } t_rsp;

    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [VALUE_BITS-1:0]   value;
        logic [COUNT_BITS-1:0]   count;
    } t_row;

    typedef struct packed {
        logic                    key_eq;
        logic                    cnt_lt;
        logic [COUNT_BITS-1:0]   cnt_inc;
    } t_cmp;

endpackage

// ===== hdl/lfu_cmp.sv =====
module lfu_cmp
    import lfu_pkg::*;
(
    input  logic [KEY_BITS-1:0]   i_entry_key,
    input  logic [KEY_BITS-1:0]   i_req_key,
    input  logic [COUNT_BITS-1:0] i_entry_cnt,
    input  logic [COUNT_BITS-1:0] i_min_cnt,
    output t_cmp                  o_cmp
);

    always_comb begin
        o_cmp.key_eq  = (i_entry_key == i_req_key);
        o_cmp.cnt_lt  = (i_entry_cnt < i_min_cnt);
        o_cmp.cnt_inc = (i_entry_cnt == {COUNT_BITS{1'b1}}) ? i_entry_cnt
                                                             : i_entry_cnt + 1'b1;
    end

endmodule

// ===== hdl/lfu_key_value_cache.sv =====
// LFU key/value cache, 16 entries, fully associative. A get, set or delete
// request runs from acceptance to the cycle the response is loaded through an
// accept step that issues the first entry read, a scan in which a single
// compare unit walks the entry memory one entry per cycle (match, first free
// slot, smallest count), and a write-back step. A clear skips the scan. The
// request side is not ready during that work; a response waiting on o_rsp
// only stalls write-back. Set does not look for an existing copy of the key,
// so duplicate keys can coexist; get and delete act on the lowest matching
// entry, set evicts the lowest-index entry with the smallest count.
module lfu_key_value_cache
    import lfu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(ENTRIES - 1);

    t_state                r_state, n_state;
    t_req                  r_req;
    logic [IDX_BITS-1:0]   r_idx;
    logic [ENTRIES-1:0]    r_valid;
    logic                  r_found;
    logic [IDX_BITS-1:0]   r_slot;
    t_row                  r_hit_row;
    logic [COUNT_BITS-1:0] r_hit_inc;
    logic [IDX_BITS-1:0]   r_min_slot;
    logic [COUNT_BITS-1:0] r_min_cnt;

    t_row                  r_mem [ENTRIES];
    t_row                  r_rd_row;

    logic                  w_accept;
    logic                  w_wr_go;
    logic                  w_we;
    logic [IDX_BITS-1:0]   w_rd_addr;
    logic [IDX_BITS-1:0]   w_wr_addr;
    t_row                  w_wr_row;
    logic [IDX_BITS-1:0]   w_set_slot;
    logic                  w_cur_valid;
    logic                  w_take;
    t_rsp                  w_rsp;
    t_cmp                  w_cmp;

    lfu_cmp u_cmp (
        .i_entry_key (r_rd_row.key),
        .i_req_key   (r_req.key),
        .i_entry_cnt (r_rd_row.count),
        .i_min_cnt   (r_min_cnt),
        .o_cmp       (w_cmp)
    );

    assign w_accept    = i_req_valid && o_req_ready;
    assign w_wr_go     = !o_rsp_valid || i_rsp_ready;
    assign w_cur_valid = r_valid[r_idx];
    assign w_set_slot  = r_found ? r_slot : r_min_slot;

    // first free entry for set, first valid match otherwise
    assign w_take = !r_found &&
                    ((r_req.req_type == REQ_SET) ? !w_cur_valid
                                                 : (w_cur_valid && w_cmp.key_eq));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        w_we        = 1'b0;
        w_rd_addr   = '0;
        w_wr_addr   = r_slot;
        w_wr_row    = r_hit_row;
        w_rsp       = '0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_state = (i_req.req_type == REQ_CLR) ? ST_WRITE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                w_rd_addr = r_idx + 1'b1;
                if (r_idx == IDX_LAST) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                case (r_req.req_type)
                    REQ_GET: begin
                        w_we           = r_found;
                        w_wr_row.count = r_hit_inc;
                        w_rsp.hit      = r_found;
                        w_rsp.value_out = r_found ? r_hit_row.value : '0;
                    end
                    REQ_SET: begin
                        w_we           = 1'b1;
                        w_wr_addr      = w_set_slot;
                        w_wr_row.key   = r_req.key;
                        w_wr_row.value = r_req.value;
                        w_wr_row.count = '0;
                    end
                    REQ_DEL: begin
                        w_rsp.hit = r_found;
                    end
                    default: begin
                    end
                endcase
                if (w_wr_go) begin
                    n_state = ST_IDLE;
                end else begin
                    w_we = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_row;
        end
        r_rd_row <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            o_rsp_valid <= 1'b0;
        end else begin
            if (r_state == ST_WRITE && w_wr_go) begin
                o_rsp_valid <= 1'b1;
                case (r_req.req_type)
                    REQ_SET: r_valid[w_set_slot] <= 1'b1;
                    REQ_DEL: begin
                        if (r_found) begin
                            r_valid[r_slot] <= 1'b0;
                        end
                    end
                    REQ_CLR: r_valid <= '0;
                    default: begin
                    end
                endcase
            end else if (i_rsp_ready) begin
                o_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req   <= i_req;
            r_idx   <= '0;
            r_found <= 1'b0;
        end
        if (r_state == ST_SCAN) begin
            r_idx <= r_idx + 1'b1;
            if (w_take) begin
                r_found   <= 1'b1;
                r_slot    <= r_idx;
                r_hit_row <= r_rd_row;
                r_hit_inc <= w_cmp.cnt_inc;
            end
            if (r_idx == '0 || w_cmp.cnt_lt) begin
                r_min_slot <= r_idx;
                r_min_cnt  <= r_rd_row.count;
            end
        end
        if (r_state == ST_WRITE && w_wr_go) begin
            o_rsp <= w_rsp;
        end
    end

`ifndef ASSERT_OFF
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_idx == IDX_LAST) |=> r_state == ST_WRITE)
        else $error("scan did not end in write-back");

    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE && w_wr_go && r_req.req_type == REQ_CLR)
            |=> r_valid == '0)
        else $error("clear left a valid entry");

    a_set_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE && w_wr_go && r_req.req_type == REQ_SET)
            |=> r_valid != '0)
        else $error("set left no valid entry");

    a_rsp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(r_state) == ST_WRITE)
        else $error("response raised outside write-back");
`endif

endmodule
